// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the arithmetic encoder.
// Each macro collapses to nothing when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("assert");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ===== rtl/aesm_pkg.sv =====
// Package for the static-model arithmetic encoder: payload types and opcodes.
// No dependencies.
package aesm_pkg;
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [13:0] SUM_MAX  = 14'h3fff;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  table_select;
    logic [7:0]  symbol;
    logic [13:0] frequency;
    logic        first_of_table;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic        last;
    logic [31:0] bit_count;
  } out_item_t;
endpackage

// ===== rtl/aesm_cum_mem.sv =====
// Cumulative frequency memory: one write port, one registered read port.
// Depends on nothing.
module aesm_cum_mem #(
  parameter int DEPTH = 1028,
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [13:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [13:0]   rdata
);
  logic [13:0] mem [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/aesm_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module aesm_divider #(
  parameter int NW = 48,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW+1:0] trial;

  assign trial = {rem, q[NW-1]} - {2'b00, den};
  assign quo = q;

  // Shift one numerator bit into the remainder each cycle while busy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        cnt  <= CW'(NW);
      end else if (busy) begin
        if (!trial[DW+1]) begin
          rem <= trial[DW:0];
          q   <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= {rem[DW-1:0], q[NW-1]};
          q   <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/arithmetic_encoder_static_models.sv =====
// Static-model arithmetic encoder top level: sequencer, coder state, output.
// Depends on aesm_pkg, aesm_cum_mem, aesm_divider and assert_macros.svh.
`include "assert_macros.svh"

// One transaction is taken at a time; in_ready is high only when idle.
// A load writes the running sum in S_LOAD; one that starts a fresh table also
// passes S_DONE, because the entry above its symbol is cleared as well.
// An encode is accepted, reads the total, upper and lower counts, checks them and
// then runs two serial divisions of CODE_BITS+15 quotient bits each. Each
// renormalization step passes S_RENRM, and each emitted bit and each follow bit
// passes S_WAIT and S_FOLL; the closing step leads to S_LAST, which releases the
// last byte. A finish emits its bit and follow bits the same way, then S_FLUSH
// releases a full byte still held back before the partial byte.
// Every byte waits while the output register is stalled.
// The last byte of each transaction is held back until the block knows that
// it is the last, so that it can carry the last flag.
// The cumulative memory has no reset; tables must be loaded before use.
module arithmetic_encoder_static_models #(
  parameter int CODE_BITS    = 16,
  parameter int SYMBOLS      = 256,
  parameter int TABLES       = 4,
  parameter int PENDING_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  aesm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aesm_pkg::out_item_t  out_data
);
  localparam int STRIDE = SYMBOLS + 1;
  localparam int DEPTH  = TABLES * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int NW     = CODE_BITS + 15;
  localparam logic [CODE_BITS-1:0] HALF = CODE_BITS'(1) << (CODE_BITS - 1);
  localparam logic [CODE_BITS-1:0] QTR1 = CODE_BITS'(1) << (CODE_BITS - 2);
  localparam logic [CODE_BITS-1:0] QTR3 = HALF | QTR1;
  localparam logic [PENDING_BITS-1:0] PMAX = '1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_RD3   = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_DIVH  = 4'd6;
  localparam logic [3:0] S_DIVL  = 4'd7;
  localparam logic [3:0] S_NARR  = 4'd8;
  localparam logic [3:0] S_RENRM = 4'd9;
  localparam logic [3:0] S_FOLL  = 4'd10;
  localparam logic [3:0] S_FLUSH = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_WAIT  = 4'd13;
  localparam logic [3:0] S_LAST  = 4'd14;

  logic [3:0] state;
  logic [3:0] ret_state;
  aesm_pkg::in_item_t item;
  logic [CODE_BITS-1:0] range_low, range_high;
  logic [PENDING_BITS-1:0] pending_follow;
  logic [7:0]  bit_shifter;
  logic [3:0]  bits_held;
  logic [31:0] emitted_bits, count_latch;
  logic [13:0] load_sum;
  logic [13:0] total, c_hi, c_lo;
  logic [CODE_BITS:0] rng;
  logic [NW-1:0] q_hi;
  logic [AW-1:0] base;
  logic [5:0]  iter;
  logic        fbit;
  logic        flip;
  logic        is_finish;
  logic [7:0]  hold_byte;
  logic        hold_valid;

  // Memory port.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [13:0]   mem_wdata, mem_rdata;

  aesm_cum_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // Divider.
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  aesm_divider #(.NW(NW), .DW(14)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(total),
    .done(div_done), .quo(div_quo)
  );

  logic [13:0] sum_ext;
  logic [14:0] sum_add;
  logic [CODE_BITS+1:0] nh, nl;
  logic [7:0] shifted;
  logic [4:0] held_next;
  logic       out_free;
  logic       push;
  aesm_pkg::out_item_t push_data;

  assign in_ready = (state == S_IDLE);
  assign base = AW'(item.table_select) * AW'(STRIDE);
  assign sum_ext = item.first_of_table ? 14'd0 : load_sum;
  assign sum_add = {1'b0, sum_ext} + {1'b0, item.frequency};
  assign nh = {2'b00, range_low} + (CODE_BITS+2)'(q_hi);
  assign nl = {2'b00, range_low} + (CODE_BITS+2)'(div_quo);
  assign shifted = {fbit ^ flip, bit_shifter[7:1]};
  assign held_next = {1'b0, bits_held} + 5'd1;
  assign out_free = !out_valid || out_ready;

  // Memory address, write and divider start control. Reads go total, upper count, lower count.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = base + AW'(item.symbol);
    mem_wdata = sum_add[14] ? aesm_pkg::SUM_MAX : sum_add[13:0];
    mem_raddr = base;
    div_start = 1'b0;
    div_num   = NW'(rng) * NW'(c_hi);
    unique case (state)
      S_LOAD: mem_we = 1'b1;
      S_DONE: begin
        mem_we    = 1'b1;
        mem_waddr = base + AW'(item.symbol) + AW'(1);
        mem_wdata = '0;
      end
      S_RD2:  mem_raddr = base + AW'(item.symbol);
      S_RD3:  mem_raddr = base + AW'(item.symbol) + AW'(1);
      S_CHK:  div_start = (total != 0) && (mem_rdata < c_hi) && (c_hi <= total);
      S_DIVH: begin
        div_num   = NW'(rng) * NW'(c_lo);
        div_start = div_done;
      end
      default: ;
    endcase
  end

  // Output push: a held byte, or the flush byte of a finish.
  always_comb begin
    push = 1'b0;
    push_data.code_byte = hold_byte;
    push_data.last      = 1'b0;
    push_data.bit_count = count_latch;
    unique case (state)
      S_WAIT: push = out_free && (held_next == 5'd8) && hold_valid;
      S_FLUSH: begin
        push = out_free;
        if (!hold_valid) begin
          push_data.code_byte = (bits_held == 0) ? 8'd0 :
                                8'(bit_shifter >> (4'd8 - bits_held));
          push_data.last      = 1'b1;
        end
      end
      S_LAST: begin
        push = out_free && hold_valid;
        push_data.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
      out_data  <= push_data;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      range_low      <= '0;
      range_high     <= '1;
      pending_follow <= '0;
      bit_shifter    <= '0;
      bits_held      <= '0;
      emitted_bits   <= '0;
      load_sum       <= '0;
      hold_valid     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item      <= in_data;
            is_finish <= (in_data.operation == aesm_pkg::OP_FINISH);
            if (in_data.operation == aesm_pkg::OP_FINISH) begin
              count_latch    <= emitted_bits;
              fbit           <= (range_low >= QTR1);
              flip           <= 1'b0;
              if (pending_follow != PMAX) pending_follow <= pending_follow + 1'b1;
              ret_state      <= S_FOLL;
              state          <= S_WAIT;
              iter           <= 6'd0;
            end else if ((in_data.operation == aesm_pkg::OP_LOAD ||
                          in_data.operation == aesm_pkg::OP_ENCODE) &&
                         32'(in_data.table_select) < 32'(TABLES) &&
                         32'(in_data.symbol) < 32'(SYMBOLS)) begin
              count_latch <= '0;
              state <= (in_data.operation == aesm_pkg::OP_LOAD) ? S_LOAD : S_RD1;
            end
          end
        end
        S_LOAD: begin
          if (item.first_of_table) state <= S_DONE;
          else state <= S_IDLE;
          load_sum <= mem_wdata;
        end
        S_RD1: begin
          rng   <= {1'b0, range_high - range_low} + 1'b1;
          state <= S_RD2;
        end
        S_RD2: begin
          total <= mem_rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          c_hi  <= mem_rdata;
          state <= S_CHK;
        end
        S_CHK: begin
          c_lo  <= mem_rdata;
          state <= S_DIVH;
        end
        S_DIVH: begin
          if (c_lo >= c_hi || total == 0 || c_hi > total) state <= S_IDLE;
          else if (div_done) begin
            q_hi  <= div_quo;
            state <= S_DIVL;
          end
        end
        S_DIVL: begin
          if (div_done) begin
            if (nh == 0 || (nh - 1'b1) < nl) state <= S_IDLE;
            else begin
              range_high <= CODE_BITS'(nh - 1'b1);
              range_low  <= CODE_BITS'(nl);
              iter       <= 6'd0;
              state      <= S_RENRM;
            end
          end
        end
        S_RENRM: begin
          if (iter == 6'(CODE_BITS)) state <= S_LAST;
          else if (range_high < HALF || range_low >= HALF) begin
            fbit       <= range_low >= HALF;
            flip       <= 1'b0;
            range_low  <= (range_low & ~HALF) << 1;
            range_high <= ((range_high & ~HALF) << 1) | CODE_BITS'(1);
            iter       <= iter + 1'b1;
            ret_state  <= S_FOLL;
            state      <= S_WAIT;
          end else if (range_low >= QTR1 && range_high < QTR3) begin
            if (pending_follow != PMAX) pending_follow <= pending_follow + 1'b1;
            range_low  <= (range_low - QTR1) << 1;
            range_high <= ((range_high - QTR1) << 1) | CODE_BITS'(1);
            iter       <= iter + 1'b1;
          end else state <= S_LAST;
        end
        S_WAIT: begin
          // Put one bit into the shifter; a full byte is held back.
          if (out_free) begin
            if (held_next == 5'd8) begin
              hold_byte    <= shifted;
              hold_valid   <= 1'b1;
              emitted_bits <= emitted_bits + 32'd8;
              bit_shifter  <= '0;
              bits_held    <= '0;
            end else begin
              bit_shifter <= shifted;
              bits_held   <= held_next[3:0];
            end
            state <= ret_state;
          end
        end
        S_FOLL: begin
          // Follow bits are the complement of the bit just emitted.
          if (pending_follow != 0) begin
            flip           <= 1'b1;
            pending_follow <= pending_follow - 1'b1;
            ret_state      <= S_FOLL;
            state          <= S_WAIT;
          end else state <= is_finish ? S_FLUSH : S_RENRM;
        end
        S_FLUSH: begin
          // Release any held byte first, then the partial byte.
          if (out_free) begin
            if (hold_valid) hold_valid <= 1'b0;
            else begin
              bit_shifter  <= '0;
              bits_held    <= '0;
              emitted_bits <= '0;
              state        <= S_IDLE;
            end
          end
        end
        S_LAST: begin
          // Release the held byte of an encode as its last one.
          if (!hold_valid) state <= S_IDLE;
          else if (out_free) begin
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_rdy_idle, clk, rst, in_ready, state == S_IDLE)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLIES(a_held, clk, rst, 1'b1, bits_held < 4'd8)
endmodule

// ===== tb/aesm_checker.sv =====
// Checker for the static-model arithmetic encoder: watches both channels,
// predicts the coded bytes and compares them. Depends on aesm_pkg.
module aesm_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  aesm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  aesm_pkg::out_item_t out_data,
  output int                  errors,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          STRIDE    = 257;
  localparam int          MAX_BYTES = 40;
  localparam longint      HALF      = 64'h8000;
  localparam longint      QTR1      = 64'h4000;
  localparam longint      QTR3      = 64'hC000;
  localparam longint      CMASK     = 64'hFFFF;
  localparam int unsigned PEND_MAX  = 255;

  // Coder state as the block should hold it.
  longint unsigned lo, hi;
  int unsigned     pend, shf, held, emitted, lsum, byte_cnt, latched_count;
  logic [13:0]     cum [0:4*STRIDE-1];
  aesm_pkg::out_item_t byte_q [$];

  assign outstanding = byte_q.size();

  task automatic push_byte(input int unsigned b);
    aesm_pkg::out_item_t e;
    if (byte_cnt < MAX_BYTES) begin
      e.code_byte = b[7:0];
      e.last      = 1'b0;
      e.bit_count = latched_count;
      byte_q.push_back(e);
      byte_cnt++;
    end
  endtask

  task automatic put_bit(input bit b);
    shf = ((shf >> 1) | (b ? 32'h80 : 32'h0)) & 32'hFF;
    held++;
    if (held >= 8) begin
      push_byte(shf);
      emitted += 8;
      shf = 0;
      held = 0;
    end
  endtask

  task automatic put_with_follow(input bit b);
    put_bit(b);
    while (pend > 0) begin
      put_bit(!b);
      pend--;
    end
  endtask

  task automatic bump_pending();
    if (pend < PEND_MAX) pend++;
  endtask

  // Narrow the interval for one symbol and renormalize.
  task automatic narrow_interval(input int t, input int s);
    longint unsigned total, c_hi, c_lo, rng, nh, nl;
    total = cum[t*STRIDE];
    c_hi  = cum[t*STRIDE + s];
    c_lo  = cum[t*STRIDE + s + 1];
    if (total == 0 || c_lo >= c_hi || c_hi > total) return;
    rng = ((hi - lo) & CMASK) + 1;
    nh = lo + (rng * c_hi) / total;
    nl = lo + (rng * c_lo) / total;
    if (nh == 0 || nh - 1 < nl) return;
    hi = (nh - 1) & CMASK;
    lo = nl & CMASK;
    for (int i = 0; i < 16; i++) begin
      if (hi < HALF) begin
        put_with_follow(1'b0);
      end else if (lo >= HALF) begin
        put_with_follow(1'b1);
        lo -= HALF;
        hi -= HALF;
      end else if (lo >= QTR1 && hi < QTR3) begin
        bump_pending();
        lo -= QTR1;
        hi -= QTR1;
      end else begin
        break;
      end
      lo = (lo << 1) & CMASK;
      hi = ((hi << 1) | 1) & CMASK;
    end
  endtask

  // Work out the bytes that one accepted transaction causes.
  task automatic predict(input aesm_pkg::in_item_t it);
    int unsigned b;
    byte_cnt = 0;
    latched_count = 0;
    case (it.operation)
      aesm_pkg::OP_LOAD: begin
        if (it.first_of_table) begin
          lsum = 0;
          cum[it.table_select*STRIDE + it.symbol + 1] = '0;
        end
        lsum += it.frequency;
        if (lsum > aesm_pkg::SUM_MAX) lsum = aesm_pkg::SUM_MAX;
        cum[it.table_select*STRIDE + it.symbol] = lsum[13:0];
      end
      aesm_pkg::OP_ENCODE: narrow_interval(it.table_select, it.symbol);
      aesm_pkg::OP_FINISH: begin
        latched_count = emitted;
        bump_pending();
        put_with_follow(lo >= QTR1);
        b = (held == 0) ? 0 : ((shf >> (8 - held)) & 32'hFF);
        push_byte(b);
        shf = 0;
        held = 0;
        emitted = 0;
      end
      default: ;
    endcase
    if (byte_cnt > 0) byte_q[byte_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lo = 0;
      hi = CMASK;
      pend = 0;
      shf = 0;
      held = 0;
      emitted = 0;
      lsum = 0;
      errors <= 0;
    end else begin
      // Compare a delivered byte against the oldest prediction.
      if (out_valid && out_ready) begin
        if (byte_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          if (out_data !== byte_q[0]) begin
            $display("%0t: mismatch, expected byte %h last %b count %0d, actual byte %h last %b count %0d",
                     $time, byte_q[0].code_byte, byte_q[0].last, byte_q[0].bit_count,
                     out_data.code_byte, out_data.last, out_data.bit_count);
            errors <= errors + 1;
          end
          void'(byte_q.pop_front());
        end
      end
      if (in_valid && in_ready) predict(in_data);
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// Top of the encoder testbench: clock, reset, stimulus with random idling
// and the verdict. Depends on aesm_pkg, aesm_checker and the encoder RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         RANDOM_ITEMS = 310;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  aesm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  aesm_pkg::out_item_t out_data;
  int                  errors, outstanding;
  bit                  written [4][258];

  arithmetic_encoder_static_models dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  aesm_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("arithmetic_encoder_static_models verification failed");
    $finish;
  end

  // Receiver: random stall before each transaction, with stall-free stretches.
  initial begin
    int stall;
    bit no_stall;
    no_stall = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) no_stall = !no_stall;
      stall = no_stall ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  bit burst = 1'b0;

  // Drive one transaction after a random gap; loads mark table entries written.
  task automatic send(input logic [1:0] op, input int t, input int s,
                      input int f, input bit first);
    aesm_pkg::in_item_t it;
    int gap;
    if ($urandom_range(0, 30) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 10);
    it.operation = op;
    it.table_select = t[1:0];
    it.symbol = s[7:0];
    it.frequency = f[13:0];
    it.first_of_table = first;
    if (gap > 0) begin
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    if (op == aesm_pkg::OP_LOAD) begin
      written[t][s] = 1'b1;
      if (first) written[t][s+1] = 1'b1;
    end
  endtask

  // Load a table: optionally a high symbol, then a contiguous run down to 0.
  task automatic load_table(input int t, input int top, input int run_top);
    bit first;
    first = 1'b1;
    if (top > run_top) begin
      send(aesm_pkg::OP_LOAD, t, top,
           $urandom_range(0, 3) == 0 ? 16383 : $urandom_range(1, 600), 1'b1);
      first = 1'b0;
    end
    for (int s = run_top; s >= 0; s--) begin
      send(aesm_pkg::OP_LOAD, t, s,
           $urandom_range(0, 8) == 0 ? 0 : $urandom_range(1, 3000), first);
      first = 1'b0;
    end
  endtask

  // Pick a symbol whose three table entries are all written, or -1.
  function automatic int pick_symbol(input int t);
    int cand [$];
    if (!written[t][0]) return -1;
    for (int s = 0; s < 256; s++)
      if (written[t][s] && written[t][s+1]) cand.push_back(s);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  initial begin
    int n, t, s, r;
    bit paused;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme symbols, saturating sums, zero frequency, all ops.
    send(aesm_pkg::OP_LOAD, 0, 255, 16383, 1'b1);
    send(aesm_pkg::OP_LOAD, 0, 128, 16383, 1'b0);
    send(aesm_pkg::OP_LOAD, 0, 0, 1, 1'b0);
    send(aesm_pkg::OP_LOAD, 3, 2, 1, 1'b1);
    send(aesm_pkg::OP_LOAD, 3, 1, 0, 1'b0);
    send(aesm_pkg::OP_LOAD, 3, 0, 16383, 1'b0);
    send(aesm_pkg::OP_ENCODE, 0, 255, 0, 1'b0);
    send(aesm_pkg::OP_ENCODE, 3, 2, 0, 1'b0);
    send(aesm_pkg::OP_ENCODE, 3, 1, 0, 1'b0);
    send(aesm_pkg::OP_ENCODE, 3, 0, 0, 1'b0);
    send(aesm_pkg::OP_ENCODE, 3, 0, 0, 1'b1);
    send(OP_UNUSED, 2, 85, 10922, 1'b1);
    send(aesm_pkg::OP_FINISH, 1, 170, 5461, 1'b0);
    send(aesm_pkg::OP_FINISH, 0, 0, 0, 1'b0);
    send(aesm_pkg::OP_ENCODE, 3, 2, 0, 1'b0);
    send(aesm_pkg::OP_ENCODE, 3, 2, 0, 1'b0);
    send(aesm_pkg::OP_FINISH, 0, 0, 0, 1'b0);

    // Random: mostly encode runs, mixed with table loads, finishes, unused opcodes and stray loads.
    n = 0;
    paused = 1'b0;
    while (n < RANDOM_ITEMS) begin
      t = $urandom_range(0, 3);
      r = $urandom_range(0, 99);
      if (!paused && n > RANDOM_ITEMS / 2) begin
        // Let the block drain completely before going on.
        wait (outstanding == 0);
        @(negedge clk);
        paused = 1'b1;
      end
      if (r < 12 || pick_symbol(t) < 0) begin
        s = $urandom_range(1, 7);
        load_table(t, $urandom_range(0, 1) ? $urandom_range(9, 255) : 0, s);
        n += s + 2;
      end else if (r < 80) begin
        repeat ($urandom_range(3, 15)) begin
          s = pick_symbol(t);
          send(aesm_pkg::OP_ENCODE, t, s, $urandom_range(0, 16383),
               $urandom_range(0, 1));
          n++;
        end
      end else if (r < 90) begin
        send(aesm_pkg::OP_FINISH, t, $urandom_range(0, 255), $urandom_range(0, 16383),
             $urandom_range(0, 1));
        n++;
      end else if (r < 95) begin
        send(OP_UNUSED, t, $urandom_range(0, 255), $urandom_range(0, 16383),
             $urandom_range(0, 1));
      end else begin
        // Stray load that perturbs an existing table.
        send(aesm_pkg::OP_LOAD, t, $urandom_range(0, 254), $urandom_range(0, 16383),
             $urandom_range(0, 1));
        n++;
      end
    end
    send(aesm_pkg::OP_FINISH, 0, 0, 0, 1'b0);

    // Drain and let any trailing activity settle.
    wait (outstanding == 0);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("arithmetic_encoder_static_models verification clean");
    end else begin
      $display("arithmetic_encoder_static_models verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aesm_pkg.sv
rtl/aesm_cum_mem.sv
rtl/aesm_divider.sv
rtl/arithmetic_encoder_static_models.sv
tb/aesm_checker.sv
tb/tb_top.sv
